@@ sv/sfr_pkg.sv @@
// Shared types and constants for the serial frame receiver.
package sfr_pkg;

  // Frame byte positions; position zero hunts the first start byte
  localparam logic [3:0] POS_START1 = 4'd0;
  localparam logic [3:0] POS_START2 = 4'd1;
  localparam logic [3:0] POS_FUNC   = 4'd2;
  localparam logic [3:0] POS_ADDR   = 4'd3;
  localparam logic [3:0] POS_DATA0  = 4'd4;
  localparam logic [3:0] POS_DATA1  = 4'd5;
  localparam logic [3:0] POS_DATA2  = 4'd6;
  localparam logic [3:0] POS_DATA3  = 4'd7;
  localparam logic [3:0] POS_CSUM   = 4'd8;
  localparam logic [3:0] POS_STOP   = 4'd9;

  // Result status codes
  localparam logic [2:0] ST_WAIT     = 3'd0;
  localparam logic [2:0] ST_REJECT   = 3'd1;
  localparam logic [2:0] ST_DATA     = 3'd2;
  localparam logic [2:0] ST_DATA_SPK = 3'd3;
  localparam logic [2:0] ST_END_SPK  = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_START1   = 3'd0;
  localparam logic [2:0] REG_START2   = 3'd1;
  localparam logic [2:0] REG_STOP     = 3'd2;
  localparam logic [2:0] REG_CODE_NRM = 3'd3;
  localparam logic [2:0] REG_CODE_SPK = 3'd4;
  localparam logic [2:0] REG_CODE_END = 3'd5;

  // One result word
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] frame_function;
    logic [7:0] frame_address;
    logic [7:0] data_first;
    logic [7:0] data_second;
    logic [7:0] data_third;
    logic [7:0] data_fourth;
  } result_t;

endpackage

@@ sv/serial_frame_receiver.sv @@
// Top level of the serial frame receiver: byte framing, checksum and frame decode.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_rx_byte, in_expected_address
//   out_    | output    | out_valid/out_stall| out_status, out_frame_*, out_data_*
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each word is decoded combinationally from the frame state; its result is
// registered on acceptance. A one-word skid register behind the output register
// keeps the input open for one more word while the output stalls; in_stall rises
// only when both hold a word. Reset (rst_n low, synchronous) empties both and
// returns the parser to hunting. cfg_ready is always high.
module serial_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] in_expected_address,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [7:0] out_frame_function,
  output logic [7:0] out_frame_address,
  output logic [7:0] out_data_first,
  output logic [7:0] out_data_second,
  output logic [7:0] out_data_third,
  output logic [7:0] out_data_fourth,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // Configuration registers
  logic [7:0] start1_r, start2_r, stop_r, code_nrm_r, code_spk_r, code_end_r;

  // Frame state
  logic [3:0] pos_r, pos_nxt, pos_eff;
  logic [7:0] csum_r, csum_nxt;
  logic [7:0] func_r, func_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic [7:0] data_r [4];
  logic [7:0] data_nxt [4];

  // Output and skid stages
  sfr_pkg::result_t res_nxt, out_r, skid_r;
  logic out_valid_r, skid_valid_r;
  logic in_fire, out_fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !skid_valid_r;
  assign out_fire  = out_valid_r && !out_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start1_r   <= 8'd0;
      start2_r   <= 8'd0;
      stop_r     <= 8'd0;
      code_nrm_r <= 8'd0;
      code_spk_r <= 8'd1;
      code_end_r <= 8'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sfr_pkg::REG_START1:   start1_r   <= cfg_data;
        sfr_pkg::REG_START2:   start2_r   <= cfg_data;
        sfr_pkg::REG_STOP:     stop_r     <= cfg_data;
        sfr_pkg::REG_CODE_NRM: code_nrm_r <= cfg_data;
        sfr_pkg::REG_CODE_SPK: code_spk_r <= cfg_data;
        sfr_pkg::REG_CODE_END: code_end_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode one byte against the frame state
  always_comb begin
    pos_eff  = (pos_r > sfr_pkg::POS_STOP) ? sfr_pkg::POS_START1 : pos_r;
    pos_nxt  = pos_eff;
    csum_nxt = csum_r;
    func_nxt = func_r;
    addr_nxt = addr_r;
    for (int k = 0; k < 4; k++) data_nxt[k] = data_r[k];
    res_nxt = '0;
    res_nxt.status = sfr_pkg::ST_WAIT;

    unique case (pos_eff)
      sfr_pkg::POS_START1: begin
        if (in_rx_byte == start1_r) pos_nxt = sfr_pkg::POS_START2;
        else res_nxt.status = sfr_pkg::ST_REJECT;
      end
      sfr_pkg::POS_START2: begin
        if (in_rx_byte == start2_r) begin
          pos_nxt = sfr_pkg::POS_FUNC;
        end else begin
          pos_nxt = sfr_pkg::POS_START1;
          res_nxt.status = sfr_pkg::ST_REJECT;
        end
      end
      sfr_pkg::POS_FUNC: begin
        func_nxt = in_rx_byte;
        csum_nxt = in_rx_byte;
        pos_nxt  = sfr_pkg::POS_ADDR;
      end
      sfr_pkg::POS_ADDR: begin
        addr_nxt = in_rx_byte;
        csum_nxt = csum_r + in_rx_byte;
        pos_nxt  = sfr_pkg::POS_DATA0;
      end
      sfr_pkg::POS_DATA0, sfr_pkg::POS_DATA1, sfr_pkg::POS_DATA2, sfr_pkg::POS_DATA3: begin
        data_nxt[pos_eff[1:0]] = in_rx_byte;
        csum_nxt = csum_r + in_rx_byte;
        pos_nxt  = pos_eff + 4'd1;
      end
      sfr_pkg::POS_CSUM: begin
        if (csum_r == in_rx_byte) begin
          pos_nxt = sfr_pkg::POS_STOP;
        end else begin
          pos_nxt = sfr_pkg::POS_START1;
          res_nxt.status = sfr_pkg::ST_REJECT;
        end
      end
      default: begin
        // Last byte: check stop and address, then classify the function code
        pos_nxt = sfr_pkg::POS_START1;
        res_nxt.status = sfr_pkg::ST_REJECT;
        if (in_rx_byte == stop_r && addr_r == in_expected_address) begin
          priority if (func_r == code_nrm_r) res_nxt.status = sfr_pkg::ST_DATA;
          else if (func_r == code_spk_r)     res_nxt.status = sfr_pkg::ST_DATA_SPK;
          else if (func_r == code_end_r)     res_nxt.status = sfr_pkg::ST_END_SPK;
          else                               res_nxt.status = sfr_pkg::ST_REJECT;
        end
        if (res_nxt.status != sfr_pkg::ST_REJECT) begin
          res_nxt.frame_function = func_r;
          res_nxt.frame_address  = addr_r;
          res_nxt.data_first     = data_r[0];
          res_nxt.data_second    = data_r[1];
          res_nxt.data_third     = data_r[2];
          res_nxt.data_fourth    = data_r[3];
        end
      end
    endcase
  end

  // Advance frame state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= sfr_pkg::POS_START1;
      csum_r <= 8'd0;
      func_r <= 8'd0;
      addr_r <= 8'd0;
      for (int k = 0; k < 4; k++) data_r[k] <= 8'd0;
    end else if (in_fire) begin
      pos_r  <= pos_nxt;
      csum_r <= csum_nxt;
      func_r <= func_nxt;
      addr_r <= addr_nxt;
      for (int k = 0; k < 4; k++) data_r[k] <= data_nxt[k];
    end
  end

  // Output register with skid stage behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_fire || !out_valid_r) begin
      out_valid_r  <= skid_valid_r || in_fire;
      skid_valid_r <= 1'b0;
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_valid_r) begin
      out_r <= skid_valid_r ? skid_r : res_nxt;
    end else if (in_fire) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_frame_function = out_r.frame_function;
  assign out_frame_address  = out_r.frame_address;
  assign out_data_first     = out_r.data_first;
  assign out_data_second    = out_r.data_second;
  assign out_data_third     = out_r.data_third;
  assign out_data_fourth    = out_r.data_fourth;

endmodule

@@ sv/sfr_checker.sv @@
// Port-level checks for the serial frame receiver, bound to its top level.
module sfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_status,
  input logic [7:0] out_frame_function,
  input logic [7:0] out_frame_address,
  input logic [7:0] out_data_first,
  input logic [7:0] out_data_second,
  input logic [7:0] out_data_third,
  input logic [7:0] out_data_fourth
);

  // Reset empties the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("result pending after reset");

  // Input backs up only behind a held result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // Status stays within its defined codes
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= sfr_pkg::ST_END_SPK)
    else $error("undefined status code");

  // Waiting and rejected words carry zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == sfr_pkg::ST_WAIT || out_status == sfr_pkg::ST_REJECT)
    |-> (out_frame_function | out_frame_address | out_data_first | out_data_second
         | out_data_third | out_data_fourth) == 8'd0)
    else $error("fields set on a non-frame result");

  // Stalled result holds its status, function and first data byte
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_frame_function) && $stable(out_data_first))
    else $error("stalled result changed");

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (.*);
